// File: rtl/pate_pkg.sv
// Package for the positional array table engine.
// Holds the table depth, the derived widths and the operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package pate_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_SORT   = 3'd2,
    FN_SEARCH = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

// File: rtl/pate_if.sv
// Request and result channel interfaces of the table engine.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
interface pate_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [5:0]         position;
  logic signed [31:0] value;
  logic               descending;
  modport source (output valid, func, position, value, descending, input ready);
  modport sink (input valid, func, position, value, descending, output ready);
endinterface

interface pate_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [4:0]         index;
  logic signed [31:0] data;
  logic               last;
  modport source (output valid, status, index, data, last, input ready);
  modport sink (input valid, status, index, data, last, output ready);
endinterface

// File: rtl/positional_array_table_engine.sv
// Positional array table engine: table memory, count and request sequencer.
// Depends on pate_pkg and pate_if. One request at a time; in_ch.ready only when idle.
// Errors answer without a table walk; the other requests walk the table where needed,
// and every result waits while out_ch stalls.
// All walks are set by the single read port of the table memory.
// Reset clears count and control; table contents are undefined until written.
`timescale 1ns / 1ps
module positional_array_table_engine
  import pate_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  pate_in_if.sink    in_ch,
  pate_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR,
    S_INS_RD, S_INS_WR, S_INS_PUT,
    S_DEL_RD0, S_DEL_GONE, S_DEL_RD, S_DEL_WR, S_DEL_FIN,
    S_SRT_RDI, S_SRT_GETI, S_SRT_RDJ, S_SRT_CMP, S_SRT_WRI, S_SRT_DONE,
    S_SCH_RD, S_SCH_CHK, S_SCH_END,
    S_RDA_RD, S_RDA_OUT
  } state_t;

  state_t             state_r;
  status_t            err_r;
  logic [CNT_W-1:0]   count_r, k_r, j_r, p_r;
  logic signed [31:0] val_r, ai_r, hold_r, pend_dat_r;
  logic [CNT_W-1:0]   pend_idx_r;
  logic               pend_v_r, desc_r;

  logic               out_valid_r, out_last_r;
  status_t            out_status_r;
  logic [4:0]         out_index_r;
  logic signed [31:0] out_data_r;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic               re, we;
  logic [IDX_W-1:0]   raddr, waddr;
  logic signed [31:0] wdata;

  logic               slot_free, sw, emit;
  logic [CMP_W-1:0]   pos_x, cnt_x;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pos_x     = CMP_W'(in_ch.position);
  assign cnt_x     = CMP_W'(count_r);
  assign sw        = desc_r ? (ai_r < rdata_r) : (rdata_r < ai_r);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

  always_comb begin
    case (state_r)
      S_ERR, S_INS_PUT, S_DEL_FIN, S_SRT_DONE, S_SCH_END, S_RDA_OUT: emit = slot_free;
      S_SCH_CHK: emit = slot_free && pend_v_r && (rdata_r == val_r);
      default:   emit = 1'b0;
    endcase
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = k_r[IDX_W-1:0];
    waddr = k_r[IDX_W-1:0];
    wdata = rdata_r;
    case (state_r)
      S_INS_RD:  begin re = 1'b1; raddr = IDX_W'(k_r - 1'b1); end
      S_INS_WR:  we = 1'b1;
      S_INS_PUT: begin
        we    = slot_free;
        waddr = p_r[IDX_W-1:0];
        wdata = val_r;
      end
      S_DEL_RD0: begin re = 1'b1; raddr = p_r[IDX_W-1:0]; end
      S_DEL_RD:  begin re = 1'b1; raddr = IDX_W'(k_r + 1'b1); end
      S_DEL_WR:  we = 1'b1;
      S_SRT_RDI, S_SCH_RD, S_RDA_RD: re = 1'b1;
      S_SRT_RDJ: begin re = 1'b1; raddr = j_r[IDX_W-1:0]; end
      S_SRT_CMP: begin we = sw; waddr = j_r[IDX_W-1:0]; wdata = ai_r; end
      S_SRT_WRI: begin we = 1'b1; wdata = ai_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (out_ch.ready && !emit) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          val_r  <= in_ch.value;
          desc_r <= in_ch.descending;
          p_r    <= CNT_W'(in_ch.position - 1'b1);
          case (in_ch.func)
            FN_INSERT: begin
              k_r <= count_r;
              if (count_r == CNT_W'(DEPTH)) begin
                err_r <= ST_FULL; state_r <= S_ERR;
              end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                err_r <= ST_BADPOS; state_r <= S_ERR;
              end else if (cnt_x >= pos_x) state_r <= S_INS_RD;
              else state_r <= S_INS_PUT;
            end
            FN_DELETE: begin
              k_r <= CNT_W'(in_ch.position - 1'b1);
              if (count_r == '0) begin
                err_r <= ST_EMPTY; state_r <= S_ERR;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                err_r <= ST_BADPOS; state_r <= S_ERR;
              end else state_r <= S_DEL_RD0;
            end
            FN_SORT, FN_SEARCH, FN_READ: begin
              k_r <= '0;
              pend_v_r <= 1'b0;
              if (count_r == '0) begin
                err_r <= ST_EMPTY; state_r <= S_ERR;
              end else if (in_ch.func == FN_SORT) state_r <= S_SRT_RDI;
              else if (in_ch.func == FN_SEARCH) state_r <= S_SCH_RD;
              else state_r <= S_RDA_RD;
            end
            default: ;
          endcase
        end
        S_ERR: if (slot_free) begin
          out_valid_r <= 1'b1; out_status_r <= err_r;
          out_index_r <= '0; out_data_r <= '0; out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_INS_RD: state_r <= S_INS_WR;
        S_INS_WR: begin
          k_r <= k_r - 1'b1;
          state_r <= (k_r - 1'b1 > p_r) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: if (slot_free) begin
          count_r <= count_r + 1'b1;
          out_valid_r <= 1'b1; out_status_r <= ST_OK;
          out_index_r <= 5'(p_r); out_data_r <= val_r; out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DEL_RD0: state_r <= S_DEL_GONE;
        S_DEL_GONE: begin
          hold_r <= rdata_r;
          state_r <= (k_r + 1'b1 < count_r) ? S_DEL_RD : S_DEL_FIN;
        end
        S_DEL_RD: state_r <= S_DEL_WR;
        S_DEL_WR: begin
          k_r <= k_r + 1'b1;
          state_r <= (CMP_W'(k_r) + 2'd2 < cnt_x) ? S_DEL_RD : S_DEL_FIN;
        end
        S_DEL_FIN: if (slot_free) begin
          count_r <= count_r - 1'b1;
          out_valid_r <= 1'b1; out_status_r <= ST_OK;
          out_index_r <= 5'(p_r); out_data_r <= hold_r; out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SRT_RDI: state_r <= S_SRT_GETI;
        S_SRT_GETI: begin
          ai_r <= rdata_r;
          j_r  <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 < count_r) ? S_SRT_RDJ : S_SRT_WRI;
        end
        S_SRT_RDJ: state_r <= S_SRT_CMP;
        S_SRT_CMP: begin
          if (sw) ai_r <= rdata_r;
          j_r <= j_r + 1'b1;
          state_r <= (j_r + 1'b1 < count_r) ? S_SRT_RDJ : S_SRT_WRI;
        end
        S_SRT_WRI: begin
          k_r <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 < count_r) ? S_SRT_RDI : S_SRT_DONE;
        end
        S_SRT_DONE: if (slot_free) begin
          out_valid_r <= 1'b1; out_status_r <= ST_OK;
          out_index_r <= '0; out_data_r <= '0; out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SCH_RD: state_r <= S_SCH_CHK;
        S_SCH_CHK: if (rdata_r != val_r || !pend_v_r || slot_free) begin
          if (rdata_r == val_r) begin
            if (pend_v_r) begin
              out_valid_r <= 1'b1; out_status_r <= ST_OK;
              out_index_r <= 5'(pend_idx_r); out_data_r <= pend_dat_r;
              out_last_r <= 1'b0;
            end
            pend_v_r   <= 1'b1;
            pend_idx_r <= k_r;
            pend_dat_r <= rdata_r;
          end
          k_r <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 < count_r) ? S_SCH_RD : S_SCH_END;
        end
        S_SCH_END: if (slot_free) begin
          out_valid_r <= 1'b1; out_last_r <= 1'b1;
          if (pend_v_r) begin
            out_status_r <= ST_OK;
            out_index_r <= 5'(pend_idx_r); out_data_r <= pend_dat_r;
          end else begin
            out_status_r <= ST_NOTFOUND;
            out_index_r <= '0; out_data_r <= '0;
          end
          state_r <= S_IDLE;
        end
        S_RDA_RD: state_r <= S_RDA_OUT;
        S_RDA_OUT: if (slot_free) begin
          out_valid_r <= 1'b1; out_status_r <= ST_OK;
          out_index_r <= 5'(k_r); out_data_r <= rdata_r;
          out_last_r <= (k_r + 1'b1 == count_r);
          k_r <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 == count_r) ? S_IDLE : S_RDA_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pate_checker.sv
// Port-level checks for the table engine, bound to the top level.
// Depends on pate_pkg for status and operation codes.
`timescale 1ns / 1ps
module pate_checker
  import pate_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [4:0]  out_index,
  input logic [31:0] out_data,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func <= FN_READ |=> !in_ready)
    else $error("request taken while busy");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_last && out_index == '0 && out_data == '0)
    else $error("malformed error result");

  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK && !in_ready)
    else $error("non-final result not ok or engine idle");

endmodule

bind positional_array_table_engine pate_checker u_pate_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.index),
  .out_data   (out_ch.data),
  .out_last   (out_ch.last)
);

// File: test/positional_array_table_engine_tb.sv
// Testbench for the positional array table engine: directed and random requests
// checked against a behavioral table predictor. Depends on pate_pkg, pate_if and the engine.
`timescale 1ns / 1ps
module positional_array_table_engine_tb;
  import pate_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         index;
    logic signed [31:0] data;
    logic               last;
  } result_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  bit   timed_out;

  pate_in_if  in_ch ();
  pate_out_if out_ch ();

  positional_array_table_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  logic signed [31:0] tbl [DEPTH];
  int                 tbl_cnt;
  result_t            expected_results[$];

  localparam int CYCLE_LIMIT = 1500000;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("positional_array_table_engine verification failed");
        $finish;
      end
    end
  end

  function automatic void push_result(status_t st, int idx, logic signed [31:0] dat,
                                      bit lst);
    result_t r;
    r.status = st;
    r.index  = idx[4:0];
    r.data   = dat;
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  // table predictor
  function automatic void predict_request(logic [2:0] fn, logic [5:0] pos,
                                          logic signed [31:0] val, logic desc);
    logic signed [31:0] t;
    int                 hits;
    bit                 sw;
    hits = 0;
    case (fn)
      FN_INSERT: begin
        if (tbl_cnt >= DEPTH) push_result(ST_FULL, 0, 0, 1);
        else if (pos < 1 || pos > tbl_cnt + 1) push_result(ST_BADPOS, 0, 0, 1);
        else begin
          for (int i = tbl_cnt; i >= pos; i--) tbl[i] = tbl[i-1];
          tbl[pos-1] = val;
          tbl_cnt++;
          push_result(ST_OK, pos - 1, val, 1);
        end
      end
      FN_DELETE: begin
        if (tbl_cnt == 0) push_result(ST_EMPTY, 0, 0, 1);
        else if (pos < 1 || pos > tbl_cnt) push_result(ST_BADPOS, 0, 0, 1);
        else begin
          t = tbl[pos-1];
          for (int i = pos - 1; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
          tbl_cnt--;
          push_result(ST_OK, pos - 1, t, 1);
        end
      end
      FN_SORT: begin
        if (tbl_cnt == 0) push_result(ST_EMPTY, 0, 0, 1);
        else begin
          for (int i = 0; i < tbl_cnt; i++)
            for (int j = i + 1; j < tbl_cnt; j++) begin
              sw = desc ? (tbl[i] < tbl[j]) : (tbl[j] < tbl[i]);
              if (sw) begin
                t = tbl[i];
                tbl[i] = tbl[j];
                tbl[j] = t;
              end
            end
          push_result(ST_OK, 0, 0, 1);
        end
      end
      FN_SEARCH: begin
        if (tbl_cnt == 0) push_result(ST_EMPTY, 0, 0, 1);
        else begin
          for (int i = 0; i < tbl_cnt; i++)
            if (tbl[i] == val) begin
              push_result(ST_OK, i, tbl[i], 0);
              hits++;
            end
          if (hits == 0) push_result(ST_NOTFOUND, 0, 0, 1);
          else expected_results[$].last = 1'b1;
        end
      end
      FN_READ: begin
        if (tbl_cnt == 0) push_result(ST_EMPTY, 0, 0, 1);
        else
          for (int i = 0; i < tbl_cnt; i++)
            push_result(ST_OK, i, tbl[i], i + 1 == tbl_cnt);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // receiver: stall pattern, result check
  logic [7:0] stall_lfsr;
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_lfsr   <= 8'hA5;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", out_ch.status, -1);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.status !== exp_r.status)
            report_mismatch("status", out_ch.status, exp_r.status);
          if (out_ch.index !== exp_r.index)
            report_mismatch("index", out_ch.index, exp_r.index);
          if (out_ch.data !== exp_r.data)
            report_mismatch("data", out_ch.data, exp_r.data);
          if (out_ch.last !== exp_r.last)
            report_mismatch("last", out_ch.last, exp_r.last);
        end
      end
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                     ^ stall_lfsr[3]};
      // stall phases: long open stretches when bit 7 set
      out_ch.ready <= stall_lfsr[7] ? 1'b1 : (stall_lfsr[1:0] != 2'b00);
    end
  end

  int burst_left;

  task automatic send_request(logic [2:0] fn, logic [5:0] pos, logic signed [31:0] val,
                              logic desc);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid      <= 1'b0;
        in_ch.func       <= 3'($urandom);
        in_ch.position   <= 6'($urandom);
        in_ch.value      <= $urandom;
        in_ch.descending <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.position   <= pos;
    in_ch.value      <= val;
    in_ch.descending <= desc;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(fn, pos, val, desc);
    burst_left--;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 3);
      3: return -$signed(32'($urandom_range(1, 3)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] table_value();
    if (tbl_cnt == 0) return pick_value();
    return tbl[$urandom_range(0, tbl_cnt - 1)];
  endfunction

  task automatic test_empty_table();
    send_request(FN_DELETE, 6'd1, 0, 0);
    send_request(FN_SORT, 6'd0, 0, 0);
    send_request(FN_SEARCH, 6'd0, 5, 0);
    send_request(FN_READ, 6'd0, 0, 0);
    send_request(FN_INSERT, 6'd0, 1, 0);
    send_request(FN_INSERT, 6'd2, 1, 0);
    send_request(3'd5, 6'd1, 1, 0);
    send_request(3'd7, 6'd63, -1, 1);
  endtask

  task automatic test_fill_and_edges();
    send_request(FN_INSERT, 6'd1, 32'sh7FFFFFFF, 0);
    send_request(FN_INSERT, 6'd1, 32'sh80000000, 0);
    send_request(FN_INSERT, 6'd3, 0, 0);
    send_request(FN_INSERT, 6'd2, -1, 0);
    send_request(FN_SEARCH, 6'd0, 7, 0);
    send_request(FN_SORT, 6'd0, 0, 1);
    send_request(FN_READ, 6'd0, 0, 0);
    send_request(FN_DELETE, 6'd5, 0, 0);
    send_request(FN_DELETE, 6'd0, 0, 0);
    send_request(FN_DELETE, 6'd4, 0, 0);
    while (tbl_cnt < DEPTH) send_request(FN_INSERT, 6'($urandom_range(1, tbl_cnt + 1)),
                                         $urandom_range(0, 2), 1'($urandom));
    send_request(FN_INSERT, 6'd1, 9, 0);
    send_request(FN_SEARCH, 6'd63, 1, 0);
    send_request(FN_SORT, 6'd0, 0, 0);
    send_request(FN_READ, 6'd0, 0, 0);
    send_request(FN_DELETE, 6'd32, 0, 0);
    send_request(FN_DELETE, 6'd33, 0, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] fn;
    int         r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) fn = FN_INSERT;
      else if (r < 60) fn = FN_DELETE;
      else if (r < 70) fn = FN_SORT;
      else if (r < 85) fn = FN_SEARCH;
      else if (r < 95) fn = FN_READ;
      else fn = 3'($urandom_range(5, 7));
      if (fn > FN_READ) k--;
      send_request(fn,
                   ($urandom_range(0, 9) == 0) ? 6'($urandom)
                     : 6'($urandom_range(1, tbl_cnt + 1)),
                   (fn == FN_SEARCH && $urandom_range(0, 2) != 0) ? table_value()
                     : pick_value(),
                   1'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    tbl_cnt = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.position = '0;
    in_ch.value = '0;
    in_ch.descending = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_fill_and_edges();
    test_random(340);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("positional_array_table_engine verification clean");
    end else begin
      $display("positional_array_table_engine verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pate_pkg.sv
rtl/pate_if.sv
rtl/positional_array_table_engine.sv
rtl/pate_checker.sv
test/positional_array_table_engine_tb.sv
